// File: rtl/zrq_pkg.sv
// Package with the zoom table, action and status codes, and the level search function.
package zrq_pkg;

	localparam int REPLY_BYTES = 7;
	localparam int TABLE_SIZE  = 41;
	localparam int LEVELS      = 41;
	localparam int LEVEL_COUNT = (LEVELS > TABLE_SIZE) ? TABLE_SIZE : LEVELS;
	localparam int LEVEL_W     = 6;
	localparam int COUNT_W     = 3;

	localparam logic [COUNT_W-1:0] HDR0_IDX = COUNT_W'(0);
	localparam logic [COUNT_W-1:0] HDR1_IDX = COUNT_W'(1);
	localparam logic [COUNT_W-1:0] TERM_IDX = COUNT_W'(REPLY_BYTES - 1);

	localparam logic [7:0]  HDR0_BYTE     = 8'h90;
	localparam logic [7:0]  HDR1_BYTE     = 8'h50;
	localparam logic [7:0]  TERM_BYTE     = 8'hFF;
	localparam logic [3:0]  NIB_MASK      = 4'hF;
	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
	localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

	typedef logic [1:0] action_t;
	localparam action_t ACT_START = 2'd0;
	localparam action_t ACT_BYTE  = 2'd1;
	localparam action_t ACT_TICK  = 2'd2;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_BAD     = 2'd1;
	localparam status_t ST_TIMEOUT = 2'd2;

	typedef logic [LEVEL_W-1:0] level_t;

	localparam logic [15:0] ZOOM_TABLE [TABLE_SIZE] = '{
		16'h0000, 16'h16A1, 16'h2063, 16'h2628, 16'h2A1D, 16'h2D13, 16'h2F6D, 16'h3161,
		16'h330D, 16'h3486, 16'h35D7, 16'h3709, 16'h3820, 16'h3920, 16'h3A0A, 16'h3ADD,
		16'h3B9C, 16'h3C46, 16'h3CDC, 16'h3D60, 16'h3DD4, 16'h3E39, 16'h3E90, 16'h3EDC,
		16'h3F1E, 16'h3F57, 16'h3F8A, 16'h3FB6, 16'h3FDC, 16'h4000, 16'h6000, 16'h6A80,
		16'h7000, 16'h7300, 16'h7540, 16'h76C0, 16'h7800, 16'h78C0, 16'h7980, 16'h7A00,
		16'h7AC0
	};

	// The first entry at or above the position is chosen; a strictly nearer lower
	// neighbor wins, so a tie keeps the upper entry.
	function automatic level_t quantize(input logic [15:0] pos);
		level_t      idx;
		logic        found;
		logic [15:0] hi;
		logic [15:0] lo;
		logic [15:0] up;
		logic [15:0] dn;
		idx   = level_t'(LEVEL_COUNT - 1);
		found = 1'b0;
		for (int i = 0; i < LEVEL_COUNT; i++) begin
			if (!found && ZOOM_TABLE[i] >= pos) begin
				found = 1'b1;
				idx   = level_t'(i);
			end
		end
		if (found && idx != '0) begin
			hi = ZOOM_TABLE[idx];
			lo = ZOOM_TABLE[idx - level_t'(1)];
			up = hi - pos;
			dn = pos - lo;
			if (up > dn) begin
				idx = idx - level_t'(1);
			end
		end
		return idx;
	endfunction

endpackage

// File: rtl/zoom_reply_quantizer_core.sv
// Zoom position reply decoder with header check, timeout and table quantization.
// Each item is held in the input register, and its result is then registered in the result register.
// Throughput: one item per cycle; the input register, state update and result register
// form a single pass, so back-to-back bytes and ticks are taken without gaps.
// A waiting result stalls the input only when the next item would also produce one.
// Reset (arst_n low) clears the reception state and loads the timeout register with 1000.
module zoom_reply_quantizer_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [15:0]      cfg_wdata,
	input  logic             req_valid,
	output logic             req_stall,
	input  zrq_pkg::action_t action,
	input  logic [7:0]       rx_byte,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output zrq_pkg::status_t status,
	output zrq_pkg::level_t  zoom_level,
	output logic [15:0]      position
);
	import zrq_pkg::*;

	logic               valid_s1;
	action_t            action_s1;
	logic [7:0]         byte_s1;

	logic [15:0]        timeout_q;
	logic               busy_q;
	logic [COUNT_W-1:0] byte_count_q;
	logic               header_ok_q;
	logic [15:0]        nibble_acc_q;
	logic [15:0]        idle_ticks_q;

	logic               busy_d;
	logic [COUNT_W-1:0] byte_count_d;
	logic               header_ok_d;
	logic [15:0]        nibble_acc_d;
	logic [15:0]        idle_ticks_d;
	logic [15:0]        ticks_inc;

	logic               res_gen;
	status_t            res_status;
	level_t             res_level;
	logic [15:0]        res_position;

	logic               out_valid_q;
	status_t            status_q;
	level_t             level_q;
	logic [15:0]        position_q;

	logic               advance;
	logic               out_free;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign advance   = !valid_s1 || !res_gen || out_free;
	assign req_stall = !advance;

	assign ticks_inc = (idle_ticks_q == TICKS_MAX) ? idle_ticks_q : idle_ticks_q + 16'd1;

	always_comb begin
		busy_d       = busy_q;
		byte_count_d = byte_count_q;
		header_ok_d  = header_ok_q;
		nibble_acc_d = nibble_acc_q;
		idle_ticks_d = idle_ticks_q;
		res_gen      = 1'b0;
		res_status   = ST_OK;
		res_level    = '0;
		res_position = '0;
		if (valid_s1) begin
			if (action_s1 == ACT_START) begin
				busy_d       = 1'b1;
				byte_count_d = '0;
				header_ok_d  = 1'b1;
				nibble_acc_d = '0;
				idle_ticks_d = '0;
			end else if (busy_q && action_s1 == ACT_BYTE) begin
				idle_ticks_d = '0;
				byte_count_d = byte_count_q + COUNT_W'(1);
				if (byte_count_q == HDR0_IDX) begin
					header_ok_d = header_ok_q && (byte_s1 == HDR0_BYTE);
				end else if (byte_count_q == HDR1_IDX) begin
					header_ok_d = header_ok_q && (byte_s1 == HDR1_BYTE);
				end else if (byte_count_q < TERM_IDX) begin
					nibble_acc_d = {nibble_acc_q[11:0], byte_s1[3:0] & NIB_MASK};
				end else begin
					header_ok_d  = header_ok_q && (byte_s1 == TERM_BYTE);
					busy_d       = 1'b0;
					byte_count_d = '0;
					res_gen      = 1'b1;
					res_position = nibble_acc_q;
					if (header_ok_d) begin
						res_status = ST_OK;
						res_level  = quantize(nibble_acc_q);
					end else begin
						res_status = ST_BAD;
					end
				end
			end else if (busy_q && action_s1 == ACT_TICK) begin
				idle_ticks_d = ticks_inc;
				if (ticks_inc >= timeout_q) begin
					busy_d       = 1'b0;
					byte_count_d = '0;
					idle_ticks_d = '0;
					res_gen      = 1'b1;
					res_status   = ST_TIMEOUT;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && req_valid) begin
			action_s1 <= action;
			byte_s1   <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			byte_count_q <= '0;
			header_ok_q  <= 1'b1;
			nibble_acc_q <= '0;
			idle_ticks_q <= '0;
		end else if (advance) begin
			busy_q       <= busy_d;
			byte_count_q <= byte_count_d;
			header_ok_q  <= header_ok_d;
			nibble_acc_q <= nibble_acc_d;
			idle_ticks_q <= idle_ticks_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && res_gen && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && res_gen && out_free) begin
			status_q   <= res_status;
			level_q    <= res_level;
			position_q <= res_position;
		end
	end

	assign rsp_valid  = out_valid_q;
	assign status     = status_q;
	assign zoom_level = level_q;
	assign position   = position_q;

`ifndef SYNTHESIS
	a_idle_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> byte_count_q == '0)
		else $error("byte count nonzero while idle");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= TERM_IDX)
		else $error("byte count beyond the terminator");

	a_timeout_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_TIMEOUT |-> zoom_level == '0 && position == '0)
		else $error("timeout result carries nonzero fields");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_OK |-> zoom_level < level_t'(LEVEL_COUNT))
		else $error("zoom level outside the table");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_gen |-> busy_q && !busy_d)
		else $error("result produced outside a reply");
`endif

endmodule

// File: test/zrq_checker.sv
// Checker that predicts zoom reply results from observed transfers and compares them.
module zrq_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [15:0]      cfg_wdata,
	input  logic             req_valid,
	input  logic             req_stall,
	input  zrq_pkg::action_t action,
	input  logic [7:0]       rx_byte,
	input  logic             rsp_valid,
	input  logic             rsp_stall,
	input  zrq_pkg::status_t status,
	input  zrq_pkg::level_t  zoom_level,
	input  logic [15:0]      position,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import zrq_pkg::*;

	localparam int         NUM_LEVELS  = 41;
	localparam int         LAST_BYTE   = 6;
	localparam int         REPORT_MAX  = 10;
	localparam logic [7:0] HEAD_A      = 8'h90;
	localparam logic [7:0] HEAD_B      = 8'h50;
	localparam logic [7:0] TAIL        = 8'hFF;

	localparam logic [15:0] LEVEL_POS [NUM_LEVELS] = '{
		16'h0000, 16'h16A1, 16'h2063, 16'h2628, 16'h2A1D, 16'h2D13, 16'h2F6D, 16'h3161,
		16'h330D, 16'h3486, 16'h35D7, 16'h3709, 16'h3820, 16'h3920, 16'h3A0A, 16'h3ADD,
		16'h3B9C, 16'h3C46, 16'h3CDC, 16'h3D60, 16'h3DD4, 16'h3E39, 16'h3E90, 16'h3EDC,
		16'h3F1E, 16'h3F57, 16'h3F8A, 16'h3FB6, 16'h3FDC, 16'h4000, 16'h6000, 16'h6A80,
		16'h7000, 16'h7300, 16'h7540, 16'h76C0, 16'h7800, 16'h78C0, 16'h7980, 16'h7A00,
		16'h7AC0
	};

	typedef struct packed {
		status_t     st;
		level_t      lvl;
		logic [15:0] pos;
	} reply_t;

	reply_t      replies_due [$];
	logic        rx_busy;
	logic [2:0]  rx_count;
	logic        hdr_good;
	logic [15:0] pos_acc;
	logic [15:0] tick_count;
	logic [15:0] timeout_reg;

	// The table rises strictly, so the nearest entry wins and a tie goes to the later one.
	function automatic level_t nearest_level(input logic [15:0] pos);
		int best;
		int best_d;
		int d;
		best   = 0;
		best_d = 1 << 20;
		for (int i = 0; i < NUM_LEVELS; i++) begin
			d = int'(LEVEL_POS[i]) - int'(pos);
			if (d < 0) begin
				d = -d;
			end
			if (d <= best_d) begin
				best   = i;
				best_d = d;
			end
		end
		return level_t'(best);
	endfunction

	task automatic advance_reply(input action_t a, input logic [7:0] b);
		reply_t r;
		case (a)
			ACT_START: begin
				rx_busy    = 1'b1;
				rx_count   = '0;
				hdr_good   = 1'b1;
				pos_acc    = '0;
				tick_count = '0;
			end
			ACT_BYTE: begin
				if (rx_busy) begin
					tick_count = '0;
					if (rx_count == 3'd0) begin
						if (b != HEAD_A) hdr_good = 1'b0;
						rx_count = rx_count + 3'd1;
					end else if (rx_count == 3'd1) begin
						if (b != HEAD_B) hdr_good = 1'b0;
						rx_count = rx_count + 3'd1;
					end else if (rx_count < 3'(LAST_BYTE)) begin
						pos_acc  = {pos_acc[11:0], b[3:0]};
						rx_count = rx_count + 3'd1;
					end else begin
						if (b != TAIL) hdr_good = 1'b0;
						rx_busy  = 1'b0;
						rx_count = '0;
						r.st     = hdr_good ? ST_OK : ST_BAD;
						r.lvl    = hdr_good ? nearest_level(pos_acc) : level_t'(0);
						r.pos    = pos_acc;
						replies_due.push_back(r);
					end
				end
			end
			ACT_TICK: begin
				if (rx_busy) begin
					if (tick_count != 16'hFFFF) tick_count = tick_count + 16'd1;
					if (tick_count >= timeout_reg) begin
						rx_busy    = 1'b0;
						rx_count   = '0;
						tick_count = '0;
						r.st       = ST_TIMEOUT;
						r.lvl      = '0;
						r.pos      = '0;
						replies_due.push_back(r);
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic log_failure(input bit orphan, input reply_t want, input reply_t got);
		if (fail_count < REPORT_MAX) begin
			if (orphan) begin
				$display("%0t: result with none predicted: status %0d level %0d position %h",
					$realtime, got.st, got.lvl, got.pos);
			end else begin
				$display("%0t: expected status %0d level %0d position %h, got %0d %0d %h",
					$realtime, want.st, want.lvl, want.pos, got.st, got.lvl, got.pos);
			end
		end
		fail_count = fail_count + 1;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		reply_t want;
		reply_t got;
		if (!arst_n) begin
			rx_busy     = 1'b0;
			rx_count    = '0;
			hdr_good    = 1'b1;
			pos_acc     = '0;
			tick_count  = '0;
			timeout_reg = 16'd1000;
			replies_due.delete();
		end else begin
			if (rsp_valid && !rsp_stall) begin
				got.st  = status;
				got.lvl = zoom_level;
				got.pos = position;
				if (replies_due.size() == 0) begin
					log_failure(1'b1, got, got);
				end else begin
					want = replies_due.pop_front();
					if (want.st !== got.st || want.lvl !== got.lvl || want.pos !== got.pos) begin
						log_failure(1'b0, want, got);
					end
				end
			end
			if (cfg_we) begin
				timeout_reg = cfg_wdata;
			end
			if (req_valid && !req_stall) begin
				advance_reply(action, rx_byte);
			end
		end
		pending = replies_due.size();
	end

endmodule

// File: test/tb_top.sv
// Testbench top that drives zoom reply stimulus and reports the verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import zrq_pkg::*;

	localparam action_t ACT_IGNORED    = 2'd3;
	localparam int      WATCHDOG_LIMIT = 4000;
	localparam int      PHASE_ITEMS    = 100;
	localparam int      SETTLE_CYCLES  = 4;
	localparam int      NUM_PHASES     = 7;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	action_t     action    = ACT_IGNORED;
	logic [7:0]  rx_byte   = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b1;
	status_t     status;
	level_t      zoom_level;
	logic [15:0] position;

	int          fail_count;
	int          pending;
	int          idle_cycles = 0;
	int          rsp_hold    = 0;
	int          stim_count  = 0;
	bit          quiet       = 1'b0;
	logic [15:0] timeout_now = 16'd1000;

	zoom_reply_quantizer_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.action     (action),
		.rx_byte    (rx_byte),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.zoom_level (zoom_level),
		.position   (position)
	);

	zrq_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.action     (action),
		.rx_byte    (rx_byte),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.zoom_level (zoom_level),
		.position   (position),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		if (rsp_hold > 0) begin
			rsp_stall <= 1'b1;
			rsp_hold  <= rsp_hold - 1;
		end else begin
			rsp_stall <= 1'b0;
			if (!quiet && $urandom_range(0, 3) == 0) begin
				rsp_hold <= pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles = idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("zoom_reply_quantizer_core: mismatch");
				$finish;
			end
		end
	end

	task automatic send(input action_t a, input logic [7:0] b);
		int  gap;
		bit  taken;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		action    <= a;
		rx_byte   <= b;
		do begin
			@(negedge clk);
			taken = !req_stall;
			@(posedge clk);
		end while (!taken);
		if (a != ACT_IGNORED) stim_count = stim_count + 1;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_timeout(input logic [15:0] v);
		cfg_we      <= 1'b1;
		cfg_wdata   <= v;
		timeout_now  = v;
		@(posedge clk);
		cfg_we      <= 1'b0;
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send(ACT_TICK, 8'($urandom));
	endtask

	function automatic int pick_ticks();
		int r;
		int top;
		r   = $urandom_range(0, 99);
		top = (int'(timeout_now) + 1 > 40) ? 40 : int'(timeout_now) + 1;
		if (top < 2) top = 2;
		if (r < 70) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(1, top);
	endfunction

	function automatic logic [15:0] pick_position();
		int          i;
		logic [16:0] mid;
		i = $urandom_range(0, TABLE_SIZE - 1);
		case ($urandom_range(0, 4))
			0: return 16'($urandom);
			1: return ZOOM_TABLE[i];
			2: return ZOOM_TABLE[i] + 16'($urandom_range(0, 6)) - 16'd3;
			3: begin
				if (i == TABLE_SIZE - 1) return 16'hFFFF;
				mid = (17'(ZOOM_TABLE[i]) + 17'(ZOOM_TABLE[i + 1])) >> 1;
				return mid[15:0] + 16'($urandom_range(0, 1));
			end
			default: return 16'($urandom_range(16'h7AC0, 16'hFFFF));
		endcase
	endfunction

	task automatic play_reply();
		logic [15:0] pos;
		logic [7:0]  b;
		pos = pick_position();
		send(ACT_START, 8'($urandom));
		for (int k = 0; k < REPLY_BYTES; k++) begin
			send_ticks(pick_ticks());
			if ($urandom_range(0, 99) < 3) return;
			case (k)
				0:       b = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h90;
				1:       b = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h50;
				6:       b = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'hFF;
				default: b = {4'($urandom), pos[4 * (5 - k) +: 4]};
			endcase
			send(ACT_BYTE, b);
		end
	endtask

	task automatic play_noise();
		repeat ($urandom_range(1, 4)) send(action_t'($urandom_range(0, 3)), 8'($urandom));
	endtask

	task automatic play_timeout();
		int n;
		n = (int'(timeout_now) > 40) ? 40 : int'(timeout_now);
		send(ACT_START, 8'($urandom));
		repeat ($urandom_range(0, 6)) send(ACT_BYTE, 8'($urandom));
		send_ticks(n + $urandom_range(0, 2));
	endtask

	initial begin
		logic [15:0] v;
		int          r;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(ACT_IGNORED, 8'hFF);
		send(ACT_TICK, 8'h00);
		send(ACT_BYTE, 8'h00);

		send(ACT_START, 8'h00);
		send(ACT_BYTE, 8'h90);
		send(ACT_START, 8'hFF);
		send(ACT_BYTE, 8'h90);
		send(ACT_BYTE, 8'h50);
		send(ACT_BYTE, 8'hF5);
		send(ACT_BYTE, 8'hF0);
		send(ACT_BYTE, 8'hF0);
		send(ACT_BYTE, 8'hF0);
		send(ACT_BYTE, 8'hFF);

		send(ACT_START, 8'h00);
		send(ACT_BYTE, 8'h90);
		send(ACT_BYTE, 8'h50);
		repeat (4) send(ACT_BYTE, 8'h0F);
		send(ACT_BYTE, 8'hFE);

		drain();
		set_timeout(16'd0);
		send(ACT_START, 8'h00);
		send(ACT_TICK, 8'h00);

		drain();
		set_timeout(16'd5);
		send(ACT_START, 8'h00);
		send(ACT_TICK, 8'h00);
		send(ACT_TICK, 8'h00);
		drain();
		set_timeout(16'd1);
		send(ACT_TICK, 8'h00);

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0:       v = 16'd1;
				1:       v = 16'hFFFF;
				2:       v = 16'd1000;
				default: v = 16'($urandom_range(2, 24));
			endcase
			drain();
			set_timeout(v);
			stim_count = 0;
			while (stim_count < PHASE_ITEMS) begin
				quiet = (p == 3) || ($urandom_range(0, 9) == 0);
				r     = $urandom_range(0, 99);
				if (r < 75) begin
					play_reply();
				end else if (r < 88) begin
					play_noise();
				end else begin
					play_timeout();
				end
				if ($urandom_range(0, 15) == 0) drain();
			end
		end
		quiet = 1'b0;

		drain();
		@(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("zoom_reply_quantizer_core: match");
		end else begin
			$display("zoom_reply_quantizer_core: mismatch");
		end
		$finish;
	end

endmodule
